/* src/bpc_pkg.sv */
package bpc_pkg;

  localparam int unsigned COEF_W = 16;
  localparam int unsigned RAW_W  = 24;
  localparam int unsigned OUT_W  = 32;
  localparam int unsigned IDX_W  = 3;
  localparam int unsigned NUM_COEFS = 6;

  // internal widths, sized to the value ranges of the compensation math
  localparam int unsigned DT_W    = 25;  // D2 - C5*256
  localparam int unsigned DEV_W   = 19;  // (dT*C6)>>23, TEMP - 2000
  localparam int unsigned TEMP_W  = 19;  // first-order temperature
  localparam int unsigned TCOR_W  = 20;  // TEMP - T2
  localparam int unsigned T2_W    = 19;  // (dT*dT)>>31
  localparam int unsigned OFF_W   = 36;  // first-order offset
  localparam int unsigned SENS_W  = 35;  // first-order sensitivity
  localparam int unsigned FIN_W   = 42;  // offset / sensitivity after correction

  // register indexes of the configuration port
  localparam logic [IDX_W-1:0] REG_SENS     = 3'd0;
  localparam logic [IDX_W-1:0] REG_OFF      = 3'd1;
  localparam logic [IDX_W-1:0] REG_TCS      = 3'd2;
  localparam logic [IDX_W-1:0] REG_TCO      = 3'd3;
  localparam logic [IDX_W-1:0] REG_TREF     = 3'd4;
  localparam logic [IDX_W-1:0] REG_TEMPSENS = 3'd5;

  // 20.00 C reference and the -15.00 C threshold seen as TEMP - 2000
  localparam logic signed [TEMP_W-1:0] TEMP_BASE = 19'sd2000;
  localparam logic signed [DEV_W-1:0]  COLD_DEV  = -19'sd3500;
  localparam logic signed [DEV_W:0]    COLD_OFS  = 20'sd3500;

  typedef struct packed {
    logic [COEF_W-1:0] sens;
    logic [COEF_W-1:0] off;
    logic [COEF_W-1:0] tcs;
    logic [COEF_W-1:0] tco;
    logic [COEF_W-1:0] tref;
    logic [COEF_W-1:0] tempsens;
  } coef_t;

  typedef struct packed {
    logic [RAW_W-1:0] raw_pressure;
    logic [RAW_W-1:0] raw_temperature;
  } in_item_t;

  typedef struct packed {
    logic signed [OUT_W-1:0] temp_first_order;
    logic signed [OUT_W-1:0] temp_corrected;
    logic signed [OUT_W-1:0] pressure_out;
  } out_item_t;

  // first-order results
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [DEV_W-1:0]  dev;
    logic signed [TEMP_W-1:0] temp;
    logic signed [T2_W-1:0]   t2;
    logic signed [OFF_W-1:0]  off;
    logic signed [SENS_W-1:0] sens;
  } temp_item_t;

  // after second-order correction
  typedef struct packed {
    logic [RAW_W-1:0]         d1;
    logic signed [TEMP_W-1:0] temp;
    logic signed [TCOR_W-1:0] tcorr;
    logic signed [FIN_W-1:0]  off;
    logic signed [FIN_W-1:0]  sens;
  } corr_item_t;

endpackage

/* src/bpc_coef_regs.sv */
module bpc_coef_regs (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::COEF_W-1:0] cfg_wdata_i,
  output bpc_pkg::coef_t             coef_o
);
  import bpc_pkg::*;

  coef_t coef_q, coef_d;

  always_comb begin
    coef_d = coef_q;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_SENS:     coef_d.sens     = cfg_wdata_i;
        REG_OFF:      coef_d.off      = cfg_wdata_i;
        REG_TCS:      coef_d.tcs      = cfg_wdata_i;
        REG_TCO:      coef_d.tco      = cfg_wdata_i;
        REG_TREF:     coef_d.tref     = cfg_wdata_i;
        REG_TEMPSENS: coef_d.tempsens = cfg_wdata_i;
        default:      coef_d = coef_q;  // unmapped index, dropped
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coef_q <= '0;
    end else begin
      coef_q <= coef_d;
    end
  end

  assign coef_o = coef_q;

endmodule

/* src/bpc_temp_stage.sv */
module bpc_temp_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  bpc_pkg::coef_t       coef_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  bpc_pkg::in_item_t    item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output bpc_pkg::temp_item_t  item_o
);
  import bpc_pkg::*;

  logic [2:0] vld_q;
  logic [3:0] en;

  // stage 1: dT
  logic [RAW_W-1:0]       d1_s1_q;
  logic signed [DT_W-1:0] dt_d, dt_q;
  // stage 2: the four dT products
  logic [RAW_W-1:0]       d1_s2_q;
  logic signed [41:0]     dtc6_d, dtc6_q, offm_d, offm_q, sensm_d, sensm_q;
  logic signed [49:0]     dtsq_d, dtsq_q;
  // stage 3
  logic signed [34:0]     offm_sh;
  logic signed [33:0]     sensm_sh;
  temp_item_t             res_d, res_q;

  always_comb begin
    en[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  assign dt_d = $signed({1'b0, item_i.raw_temperature}) - $signed({1'b0, coef_i.tref, 8'b0});

  assign dtc6_d  = dt_q * $signed({1'b0, coef_i.tempsens});
  assign offm_d  = dt_q * $signed({1'b0, coef_i.tco});
  assign sensm_d = dt_q * $signed({1'b0, coef_i.tcs});
  assign dtsq_d  = dt_q * dt_q;

  // arithmetic right shifts as part-selects (floor)
  assign offm_sh  = offm_q[41:7];
  assign sensm_sh = sensm_q[41:8];

  always_comb begin
    res_d.d1   = d1_s2_q;
    res_d.dev  = dtc6_q[41:23];
    res_d.temp = dtc6_q[41:23] + TEMP_BASE;
    res_d.t2   = dtsq_q[49:31];
    res_d.off  = $signed({4'b0, coef_i.off, 16'b0}) + $signed({offm_sh[34], offm_sh});
    res_d.sens = $signed({4'b0, coef_i.sens, 15'b0}) + $signed({sensm_sh[33], sensm_sh});
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      d1_s1_q <= item_i.raw_pressure;
      dt_q    <= dt_d;
    end
    if (en[1]) begin
      d1_s2_q <= d1_s1_q;
      dtc6_q  <= dtc6_d;
      offm_q  <= offm_d;
      sensm_q <= sensm_d;
      dtsq_q  <= dtsq_d;
    end
    if (en[2]) begin
      res_q <= res_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[2];
  assign item_o  = res_q;

endmodule

/* src/bpc_corr_stage.sv */
module bpc_corr_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  bpc_pkg::temp_item_t  item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output bpc_pkg::corr_item_t  item_o
);
  import bpc_pkg::*;

  logic [2:0] vld_q;
  logic [3:0] en;

  // stage 4: squares and temperature range flags
  temp_item_t              it4_q;
  logic signed [DEV_W:0]   cold_d;
  logic signed [37:0]      sq_d, sq_q;
  logic signed [39:0]      sq2_d, sq2_q;
  logic                    warm_lo_q, cold_q;   // below 20.00 C, below -15.00 C
  // stage 5: OFF2, SENS2
  temp_item_t              it5_q;
  logic signed [40:0]      sq_x, sq2_x, sq5, sq2_7, sq2_h, sq2_11;
  logic signed [40:0]      off2_d, off2_q, sens2_d, sens2_q;
  logic                    warm_lo5_q;
  // stage 6
  corr_item_t              res_d, res_q;

  always_comb begin
    en[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  assign cold_d = $signed({item_i.dev[DEV_W-1], item_i.dev}) + COLD_OFS;  // TEMP + 1500
  assign sq_d   = item_i.dev * item_i.dev;
  assign sq2_d  = cold_d * cold_d;

  always_comb begin
    sq_x   = 41'(sq_q);
    sq2_x  = 41'(sq2_q);
    sq5    = (sq_x <<< 2) + sq_x;
    sq2_7  = (sq2_x <<< 3) - sq2_x;
    sq2_h  = sq2_x >>> 1;
    sq2_11 = (sq2_h <<< 3) + (sq2_h <<< 1) + sq2_h;
    off2_d  = '0;
    sens2_d = '0;
    if (warm_lo_q) begin
      off2_d  = (sq5 >>> 1) + (cold_q ? sq2_7 : 41'sd0);
      sens2_d = (sq5 >>> 2) + (cold_q ? sq2_11 : 41'sd0);
    end
  end

  always_comb begin
    res_d.d1    = it5_q.d1;
    res_d.temp  = it5_q.temp;
    res_d.tcorr = $signed({it5_q.temp[TEMP_W-1], it5_q.temp})
                - (warm_lo5_q ? $signed({it5_q.t2[T2_W-1], it5_q.t2}) : 20'sd0);
    res_d.off   = 42'(it5_q.off) - 42'(off2_q);
    res_d.sens  = 42'(it5_q.sens) - 42'(sens2_q);
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      it4_q     <= item_i;
      sq_q      <= sq_d;
      sq2_q     <= sq2_d;
      warm_lo_q <= item_i.dev[DEV_W-1];
      cold_q    <= item_i.dev < COLD_DEV;
    end
    if (en[1]) begin
      it5_q      <= it4_q;
      off2_q     <= off2_d;
      sens2_q    <= sens2_d;
      warm_lo5_q <= warm_lo_q;
    end
    if (en[2]) begin
      res_q <= res_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[2];
  assign item_o  = res_q;

  // -15.00 C range lies inside the below-20.00 C range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] && cold_q |-> warm_lo_q)
    else $error("cold flag without low-temperature flag");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> !sq_q[37])
    else $error("square went negative");

  // no correction at or above 20.00 C
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && !warm_lo5_q |-> (off2_q == '0) && (sens2_q == '0))
    else $error("second-order terms nonzero above 20.00 C");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[1] && warm_lo5_q |-> !off2_q[40] && !sens2_q[40])
    else $error("second-order terms negative");

endmodule

/* src/bpc_press_stage.sv */
module bpc_press_stage (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 valid_i,
  output logic                 ready_o,
  input  bpc_pkg::corr_item_t  item_i,
  output logic                 valid_o,
  input  logic                 ready_i,
  output bpc_pkg::out_item_t   item_o
);
  import bpc_pkg::*;

  localparam int unsigned LO_W = 21;

  logic [2:0] vld_q;
  logic [3:0] en;

  // stage 7: D1 * SENS as two partial products
  logic signed [TEMP_W-1:0] temp7_q, temp8_q;
  logic signed [TCOR_W-1:0] tcor7_q, tcor8_q;
  logic signed [FIN_W-1:0]  off7_q, off8_q;
  logic [44:0]              plo_d, plo_q;
  logic signed [45:0]       phi_d, phi_q;
  // stage 8: full product
  logic signed [66:0]       prod_d, prod_q;
  // stage 9
  logic signed [46:0]       diff;
  out_item_t                res_d, res_q;

  always_comb begin
    en[3] = ready_i;
    for (int k = 2; k >= 0; k--) begin
      en[k] = !vld_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      if (en[0]) vld_q[0] <= valid_i;
      if (en[1]) vld_q[1] <= vld_q[0];
      if (en[2]) vld_q[2] <= vld_q[1];
    end
  end

  assign plo_d = item_i.d1 * item_i.sens[LO_W-1:0];
  assign phi_d = $signed({1'b0, item_i.d1}) * $signed(item_i.sens[FIN_W-1:LO_W]);

  assign prod_d = $signed({phi_q, {LO_W{1'b0}}}) + $signed({22'b0, plo_q});

  always_comb begin
    diff = $signed(prod_q[66:21]) - 47'(off8_q);
    res_d.temp_first_order = 32'(temp8_q);
    res_d.temp_corrected   = 32'(tcor8_q);
    res_d.pressure_out     = diff[46:15];
  end

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      temp7_q <= item_i.temp;
      tcor7_q <= item_i.tcorr;
      off7_q  <= item_i.off;
      plo_q   <= plo_d;
      phi_q   <= phi_d;
    end
    if (en[1]) begin
      temp8_q <= temp7_q;
      tcor8_q <= tcor7_q;
      off8_q  <= off7_q;
      prod_q  <= prod_d;
    end
    if (en[2]) begin
      res_q <= res_d;
    end
  end

  assign ready_o = en[0];
  assign valid_o = vld_q[2];
  assign item_o  = res_q;

endmodule

/* src/barometer_pressure_compensation.sv */
// Second-order compensation for a 24-bit barometric pressure sensor. Each item
// is one raw pressure (D1) and one raw temperature (D2) conversion; the result
// item holds the first-order temperature, the second-order corrected
// temperature (both in 0.01 C) and the compensated pressure (0.01 mbar), each
// wrapped to 32 bits. The six calibration words are written through the
// cfg_we_i / cfg_idx_i / cfg_wdata_i port (index 0..5, higher indexes are
// ignored) and must only change while no item is in flight.
// Throughput is one item per clock unless out_ready_i stalls the pipeline.
// An accepted item passes nine register stages before its result item
// appears on out_data_o. The nine stages: dT; the dT products; TEMP/OFF/SENS;
// squares of the temperature deviation; OFF2/SENS2; corrected OFF/SENS; D1*SENS
// as two partial products; their sum; subtraction of OFF and final shift.
// Every stage holds its own valid bit, so a stall on out_ready_i only backs
// up until the bubbles are filled, and in_ready_o stays high while any stage
// is empty.

module barometer_pressure_compensation (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // configuration
  input  logic                       cfg_we_i,
  input  logic [bpc_pkg::IDX_W-1:0]  cfg_idx_i,
  input  logic [bpc_pkg::COEF_W-1:0] cfg_wdata_i,
  // input items
  input  logic                       in_valid_i,
  output logic                       in_ready_o,
  input  bpc_pkg::in_item_t          in_data_i,
  // result items
  output logic                       out_valid_o,
  input  logic                       out_ready_i,
  output bpc_pkg::out_item_t         out_data_o
);
  import bpc_pkg::*;

  coef_t      coef;
  temp_item_t temp_item;
  corr_item_t corr_item;
  logic       temp_valid, temp_ready;
  logic       corr_valid, corr_ready;

  bpc_coef_regs u_coef (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .coef_o      (coef)
  );

  // stages 1-3: first-order temperature, offset, sensitivity
  bpc_temp_stage u_temp (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .coef_i  (coef),
    .valid_i (in_valid_i),
    .ready_o (in_ready_o),
    .item_i  (in_data_i),
    .valid_o (temp_valid),
    .ready_i (temp_ready),
    .item_o  (temp_item)
  );

  // stages 4-6: low-temperature correction
  bpc_corr_stage u_corr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (temp_valid),
    .ready_o (temp_ready),
    .item_i  (temp_item),
    .valid_o (corr_valid),
    .ready_i (corr_ready),
    .item_o  (corr_item)
  );

  // stages 7-9: pressure
  bpc_press_stage u_press (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (corr_valid),
    .ready_o (corr_ready),
    .item_i  (corr_item),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .item_o  (out_data_o)
  );

endmodule
